FILE: src/lifrk_pkg.sv
// Package for the ordered list with insert-at-front and remove-by-key.
// Holds sizes, field widths, status codes and controller/datapath types.
// No dependencies.
`default_nettype none

package lifrk_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int COUNT_W  = $clog2(DEPTH + 1);

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [COUNT_W-1:0]    count_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE   = 3'b001,
      FSM_SEARCH = 3'b010,
      FSM_UPDATE = 3'b100
   } fsm_type;

   typedef struct packed {
      logic load;
      logic search;
      logic update;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

FILE: src/lifrk_if.sv
// Handshake channels for the list block: request and response interfaces.
// Depends on lifrk_pkg.
`default_nettype none

interface lifrk_req_if;
   import lifrk_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [VALUE_W-1:0] value;
   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface lifrk_rsp_if;
   import lifrk_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [COUNT_OUT_W-1:0] count;
   modport source (output valid, output status, output count, input ready);
   modport sink   (input valid, input status, input count, output ready);
endinterface

`default_nettype wire

FILE: src/lifrk_ctrl.sv
// Controller for the list block: sequences accept, search and update.
// Depends on lifrk_pkg.
`default_nettype none

module lifrk_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  lifrk_pkg::dp_sts_type   dp_sts,
   output lifrk_pkg::dp_cmd_type   dp_cmd
);
   import lifrk_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = FSM_SEARCH;
            end
         end
         FSM_SEARCH: begin
            dp_cmd.search = 1'b1;
            state_in      = FSM_UPDATE;
         end
         FSM_UPDATE: begin
            // hold until the output register can take the result
            if (dp_sts.out_free) begin
               dp_cmd.update = 1'b1;
               state_in      = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/lifrk_dpath.sv
// Datapath for the list block: entry registers, key compare, shift and
// the response output register. Depends on lifrk_pkg.
`default_nettype none

module lifrk_dpath (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_opcode,
   input  wire signed [lifrk_pkg::VALUE_W-1:0]       req_value,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready,
   output logic [lifrk_pkg::STATUS_W-1:0]            rsp_status,
   output logic [lifrk_pkg::COUNT_OUT_W-1:0]         rsp_count,
   input  lifrk_pkg::dp_cmd_type                     dp_cmd,
   output lifrk_pkg::dp_sts_type                     dp_sts
);
   import lifrk_pkg::*;

   word_type            entries_ff [DEPTH];
   word_type            entries_in [DEPTH];
   word_type            key_ff;
   opcode_type          op_ff;
   count_type           count_ff;
   count_type           count_in;
   logic [DEPTH-1:0]    match_in;
   logic [DEPTH-1:0]    shift_ff;
   logic [DEPTH-1:0]    shift_in;
   logic                found_ff;
   logic                write_en;
   status_type          status_in;
   logic                out_valid_ff;
   status_type          out_status_ff;
   count_type           out_count_ff;
   logic                is_full;
   logic                is_empty;

   // compare every live entry with the key and mark positions at or after
   // the first match
   always_comb begin
      logic [DEPTH-1:0] upto;
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (entries_ff[i] == key_ff) && (COUNT_W'(i) < count_ff);
      end
      for (int i = 0; i < DEPTH; i++) begin
         upto        = {DEPTH{1'b1}} >> (DEPTH - 1 - i);
         shift_in[i] = |(match_in & upto);
      end
   end

   assign is_full  = (count_ff == COUNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      write_en  = 1'b0;
      count_in  = count_ff;
      status_in = ST_DONE;
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end
      if (op_ff == OP_INSERT) begin
         if (is_full) begin
            status_in = ST_FULL;
         end else begin
            write_en      = 1'b1;
            count_in      = count_ff + COUNT_W'(1);
            entries_in[0] = key_ff;
            for (int i = 1; i < DEPTH; i++) begin
               entries_in[i] = entries_ff[i-1];
            end
         end
      end else begin
         if (is_empty) begin
            status_in = ST_EMPTY;
         end else if (!found_ff) begin
            status_in = ST_NOT_FOUND;
         end else begin
            write_en = 1'b1;
            count_in = count_ff - COUNT_W'(1);
            for (int i = 0; i < DEPTH - 1; i++) begin
               if (shift_ff[i]) begin
                  entries_in[i] = entries_ff[i+1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         key_ff <= req_value[DATA_WIDTH-1:0];
         op_ff  <= opcode_type'(req_opcode);
      end
      if (dp_cmd.search) begin
         shift_ff <= shift_in;
         found_ff <= |match_in;
      end
      if (dp_cmd.update && write_en) begin
         for (int i = 0; i < DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
      if (dp_cmd.update) begin
         out_status_ff <= status_in;
         out_count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.update) begin
            count_ff     <= count_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign dp_sts.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_count       = COUNT_OUT_W'(out_count_ff);

endmodule

`default_nettype wire

FILE: src/list_insert_front_remove_key.sv
// Ordered list of signed words with insert-at-front and remove-first-match.
// Top level: joins lifrk_ctrl and lifrk_dpath. Depends on lifrk_pkg, lifrk_if.
//
// Usage:
//   req_if carries one item: opcode (0 insert at front, 1 remove the first
//   entry equal to value) and a 32-bit signed value. rsp_if returns one item
//   per request: a status (done, not found, list empty, list full) and the
//   entry count after the request. Up to DEPTH entries are held.
//   An item is accepted when valid and ready are both high.
//   The controller takes a request, compares the key against all entries in
//   its search state, then shifts the entry registers and loads the response
//   register in its update state. A new request is accepted only once the
//   previous one has left its update state.
//   A response waiting on a stalled receiver does not block the next
//   request's accept and search; its update waits until the response
//   register is free.
//   Reset clears the entry count and the response valid; entry contents are
//   not cleared and are never read beyond the count.
`default_nettype none

module list_insert_front_remove_key (
   input  wire          clock,
   input  wire          reset,
   lifrk_req_if.sink    req_if,
   lifrk_rsp_if.source  rsp_if
);
   import lifrk_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   lifrk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .dp_sts    (dp_sts),
      .dp_cmd    (dp_cmd)
   );

   lifrk_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_opcode (req_if.opcode),
      .req_value  (req_if.value),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_status (rsp_if.status),
      .rsp_count  (rsp_if.count),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Testbench for list_insert_front_remove_key: directed and random insert/remove items,
// checked against a queue-based list predictor held in a scoreboard class.
// Depends on lifrk_pkg, lifrk_if and the list RTL.
`timescale 1ns / 1ps

module testbench;
   import lifrk_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RANDOM_ITEMS = 450;
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      status_type             status;
      logic [COUNT_OUT_W-1:0] count;
   } reply_type;

   class list_scoreboard;
      word_type  held[$];
      reply_type awaited[$];
      int        failures = 0;

      function void note_request(opcode_type op, word_type key);
         reply_type r;
         int hit;
         hit = -1;
         if (op == OP_INSERT) begin
            if (held.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held.push_front(key);
               r.status = ST_DONE;
            end
         end else if (held.size() == 0) begin
            r.status = ST_EMPTY;
         end else begin
            foreach (held[i])
               if (hit < 0 && held[i] == key)
                  hit = i;
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               held.delete(hit);
               r.status = ST_DONE;
            end
         end
         r.count = COUNT_OUT_W'(held.size());
         awaited = {awaited, r};
      endfunction

      function void check_reply(logic [STATUS_W-1:0] status, logic [COUNT_OUT_W-1:0] count);
         reply_type e;
         if (awaited.size() == 0) begin
            $display("%0t: reply with none awaited, actual status %0d count %0d",
                     $time, status, count);
            failures++;
            return;
         end
         e = awaited.pop_front();
         if (status !== e.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time, e.status, status);
            failures++;
         end
         if (count !== e.count) begin
            $display("%0t: count mismatch, expected %0d actual %0d", $time, e.count, count);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   idle_cycles = 0;

   list_scoreboard sb = new();

   lifrk_req_if req_if();
   lifrk_rsp_if rsp_if();

   list_insert_front_remove_key DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.opcode = OP_INSERT;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_reply(rsp_if.status, rsp_if.count);
      rsp_if.ready <= quiet || ($urandom_range(99) >= 25);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_request(opcode_type op, word_type key);
      while (!quiet && $urandom_range(99) < 25) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.opcode <= op;
      req_if.value <= key;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(op, key);
   endtask

   task automatic run_directed();
      send_request(OP_REMOVE, 32'h0000_0005);
      send_request(OP_INSERT, 32'h8000_0000);
      send_request(OP_INSERT, 32'h7fff_ffff);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_INSERT, 32'hffff_ffff);
      send_request(OP_REMOVE, 32'h0000_0001);
      send_request(OP_REMOVE, 32'h7fff_ffff);
      send_request(OP_REMOVE, 32'h8000_0001);
      for (int i = 0; i < 13; i++)
         send_request(OP_INSERT, (i % 4 == 0) ? 32'h0000_0000 : $urandom);
      send_request(OP_INSERT, 32'h1234_5678);
      send_request(OP_REMOVE, 32'h8000_0000);
      send_request(OP_REMOVE, 32'h0000_0000);
   endtask

   task automatic run_random();
      int mode;
      int pick;
      int slot;
      opcode_type op;
      word_type key;
      mode = 2;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            mode = $urandom_range(2);
         quiet = (n >= 200 && n < 280);
         pick = $urandom_range(99);
         case (mode)
            0: op = (pick < 80) ? OP_INSERT : OP_REMOVE;
            1: op = (pick < 20) ? OP_INSERT : OP_REMOVE;
            default: op = (pick < 50) ? OP_INSERT : OP_REMOVE;
         endcase
         pick = $urandom_range(99);
         if (op == OP_INSERT) begin
            if (pick < 15)
               case ($urandom_range(3))
                  0: key = 32'h8000_0000;
                  1: key = 32'h7fff_ffff;
                  2: key = 32'hffff_ffff;
                  default: key = 32'h0000_0000;
               endcase
            else if (pick < 40)
               key = $urandom_range(7);
            else
               key = $urandom;
         end else if (sb.held.size() != 0 && pick < 85) begin
            slot = $urandom_range(sb.held.size() - 1);
            key = sb.held[slot];
            if (pick >= 70)
               key[$urandom_range(DATA_WIDTH - 1)] ^= 1'b1;
         end else begin
            key = (pick < 92) ? word_type'($urandom_range(7)) : word_type'($urandom);
         end
         send_request(op, key);
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_if.valid <= 1'b0;
      while (sb.awaited.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
